// ----- rtl/phntc_pkg.sv -----
// Package for the package header and name-table checker.
// Holds the transaction types, status codes, register indexes and header constants.
// No dependencies.
package phntc_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIGNATURE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERSION   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_NAME  = 2'd2;

   localparam logic [31:0] SIGNATURE_RESET = 32'h9E2A_83C1;
   localparam logic [15:0] VERSION_RESET   = 16'd68;
   localparam logic [12:0] NAME_LIMIT      = 13'd4096;

   localparam logic [31:0] HEADER_BYTES    = 32'd36;
   localparam logic [31:0] POSITION_MAX    = 32'hFFFF_FFFF;

   typedef enum logic [3:0] {
      ST_OK              = 4'd0,
      ST_SHORT_HEADER    = 4'd1,
      ST_SIGNATURE       = 4'd2,
      ST_VERSION         = 4'd3,
      ST_OFFSET_PAST_END = 4'd4,
      ST_NAME_IN_HEADER  = 4'd5,
      ST_BAD_LENGTH      = 4'd6,
      ST_NO_TERMINATOR   = 4'd7,
      ST_TRUNCATED       = 4'd8,
      ST_EMPTY_FIRST     = 4'd9
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  status;
      logic [15:0] version;
      logic [31:0] name_count;
      logic [31:0] names_parsed;
      logic [31:0] export_count;
      logic [31:0] import_count;
      logic [31:0] byte_count;
      logic [11:0] first_name_length;
   } rsp_type;

   // Parser state captured on the last byte of a file
   typedef struct packed {
      logic [31:0] byte_count;
      logic [31:0] signature;
      logic [15:0] version;
      logic [31:0] name_count;
      logic [31:0] name_offset;
      logic [31:0] export_count;
      logic [31:0] export_offset;
      logic [31:0] import_count;
      logic [31:0] import_offset;
      status_type  error_code;
      logic        table_done;
      logic [31:0] names_parsed;
      logic [11:0] first_length;
   } snap_type;

endpackage

// ----- rtl/phntc_parser.sv -----
// Byte-wise parser: header fields, skip to the name table, then the table walk.
// Captures a snapshot of the parse on the last byte of each file.
// Depends on phntc_pkg.
module phntc_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  phntc_pkg::req_type in_data,
   input  logic [12:0]        max_name_length,
   input  logic               out_free,
   output logic               in_fire,
   output logic               snap_valid,
   output phntc_pkg::snap_type snap
);
   import phntc_pkg::*;

   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_SKIP   = 6'b000010,
      PH_INDEX  = 6'b000100,
      PH_NAME   = 6'b001000,
      PH_FLAGS  = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] sig_ff, sig_in;
   logic [15:0] ver_ff, ver_in;
   logic [31:0] name_count_ff, name_count_in;
   logic [31:0] name_off_ff, name_off_in;
   logic [31:0] exp_count_ff, exp_count_in;
   logic [31:0] exp_off_ff, exp_off_in;
   logic [31:0] imp_count_ff, imp_count_in;
   logic [31:0] imp_off_ff, imp_off_in;
   logic [2:0]  step_ff, step_in;
   logic        neg_ff, neg_in;
   logic [12:0] name_left_ff, name_left_in;
   logic [2:0]  flags_left_ff, flags_left_in;
   logic [31:0] parsed_ff, parsed_in;
   logic [11:0] first_ff, first_in;
   status_type  err_ff, err_in;
   logic        snap_valid_ff;
   snap_type    snap_ff;

   logic        snap_free;
   logic [7:0]  b;
   logic [2:0]  step_cur;
   logic [31:0] acc_new;
   logic        more;
   logic        neg_cur;
   logic [12:0] limit;
   logic [31:0] full_word;
   snap_type    snap_build;

   assign b         = in_data.data_byte;
   assign snap_free = !snap_valid_ff || out_free;
   // a last byte waits until the snapshot slot is free
   assign in_fire   = in_valid && (!in_data.last_byte || snap_free);
   assign limit     = (max_name_length > NAME_LIMIT) ? NAME_LIMIT : max_name_length;
   assign full_word = {b, acc_ff[23:0]};

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      sig_in        = sig_ff;
      ver_in        = ver_ff;
      name_count_in = name_count_ff;
      name_off_in   = name_off_ff;
      exp_count_in  = exp_count_ff;
      exp_off_in    = exp_off_ff;
      imp_count_in  = imp_count_ff;
      imp_off_in    = imp_off_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      name_left_in  = name_left_ff;
      flags_left_in = flags_left_ff;
      parsed_in     = parsed_ff;
      first_in      = first_ff;
      err_in        = err_ff;
      step_cur      = step_ff;
      acc_new       = acc_ff;
      more          = 1'b0;
      neg_cur       = neg_ff;
      if (in_fire) begin
         pos_in = (pos_ff == POSITION_MAX) ? pos_ff : pos_ff + 32'd1;
         case (phase_ff)
            PH_HEADER: begin
               case (pos_ff[1:0])
                  2'd0: acc_in = {24'd0, b};
                  2'd1: acc_in = acc_ff | {16'd0, b, 8'd0};
                  2'd2: acc_in = acc_ff | {8'd0, b, 16'd0};
                  default: begin
                     acc_in = full_word;
                     case (pos_ff[5:2])
                        4'd0: sig_in        = full_word;
                        4'd1: ver_in        = full_word[15:0];
                        4'd3: name_count_in = full_word;
                        4'd4: name_off_in   = full_word;
                        4'd5: exp_count_in  = full_word;
                        4'd6: exp_off_in    = full_word;
                        4'd7: imp_count_in  = full_word;
                        4'd8: imp_off_in    = full_word;
                        default: ;
                     endcase
                  end
               endcase
               if (pos_ff == HEADER_BYTES - 32'd1) begin
                  acc_in = '0;
                  if (name_off_ff < HEADER_BYTES || name_count_ff == 32'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP, PH_INDEX: begin
               // the byte at the name offset is already the first index byte
               if (phase_ff == PH_INDEX || pos_ff == name_off_ff) begin
                  step_cur = (phase_ff == PH_SKIP) ? 3'd0 : step_ff;
                  case (step_cur)
                     3'd0: begin
                        neg_cur = b[7];
                        acc_new = {26'd0, b[5:0]};
                        more    = b[6];
                     end
                     3'd1: begin
                        acc_new = acc_ff | {19'd0, b[6:0], 6'd0};
                        more    = b[7];
                     end
                     3'd2: begin
                        acc_new = acc_ff | {12'd0, b[6:0], 13'd0};
                        more    = b[7];
                     end
                     3'd3: begin
                        acc_new = acc_ff | {5'd0, b[6:0], 20'd0};
                        more    = b[7];
                     end
                     default: begin
                        acc_new = acc_ff | {b[4:0], 27'd0};
                        more    = b[7];
                     end
                  endcase
                  neg_in = neg_cur;
                  acc_in = acc_new;
                  if (!more) begin
                     step_in = 3'd0;
                     if (neg_cur || acc_new == 32'd0 || acc_new[31:13] != 19'd0 ||
                         acc_new[12:0] > limit) begin
                        err_in   = ST_BAD_LENGTH;
                        phase_in = PH_DONE;
                     end else begin
                        name_left_in = acc_new[12:0];
                        if (parsed_ff == 32'd0) begin
                           first_in = acc_new[11:0] - 12'd1;
                        end
                        phase_in = PH_NAME;
                     end
                  end else if (step_cur == 3'd4) begin
                     // index still running after five bytes
                     step_in  = 3'd0;
                     err_in   = ST_BAD_LENGTH;
                     phase_in = PH_DONE;
                  end else begin
                     step_in  = step_cur + 3'd1;
                     phase_in = PH_INDEX;
                  end
               end
            end
            PH_NAME: begin
               name_left_in = name_left_ff - 13'd1;
               if (name_left_ff == 13'd1) begin
                  if (b != 8'd0) begin
                     err_in   = ST_NO_TERMINATOR;
                     phase_in = PH_DONE;
                  end else begin
                     flags_left_in = 3'd4;
                     phase_in      = PH_FLAGS;
                  end
               end
            end
            PH_FLAGS: begin
               flags_left_in = flags_left_ff - 3'd1;
               if (flags_left_ff == 3'd1) begin
                  parsed_in = parsed_ff + 32'd1;
                  step_in   = 3'd0;
                  phase_in  = (parsed_ff + 32'd1 == name_count_ff) ? PH_DONE : PH_INDEX;
               end
            end
            PH_DONE: ;
            default: phase_in = PH_DONE;
         endcase
      end
   end

   always_comb begin
      snap_build.byte_count    = pos_in;
      snap_build.signature     = sig_in;
      snap_build.version       = ver_in;
      snap_build.name_count    = name_count_in;
      snap_build.name_offset   = name_off_in;
      snap_build.export_count  = exp_count_in;
      snap_build.export_offset = exp_off_in;
      snap_build.import_count  = imp_count_in;
      snap_build.import_offset = imp_off_in;
      snap_build.error_code    = err_in;
      snap_build.table_done    = (phase_in == PH_DONE);
      snap_build.names_parsed  = parsed_in;
      snap_build.first_length  = first_in;
   end

   always_ff @(posedge clock) begin
      // the last byte of a file returns the parser to its reset state
      if (reset || (in_fire && in_data.last_byte)) begin
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         acc_ff        <= '0;
         sig_ff        <= '0;
         ver_ff        <= '0;
         name_count_ff <= '0;
         name_off_ff   <= '0;
         exp_count_ff  <= '0;
         exp_off_ff    <= '0;
         imp_count_ff  <= '0;
         imp_off_ff    <= '0;
         step_ff       <= '0;
         neg_ff        <= 1'b0;
         name_left_ff  <= '0;
         flags_left_ff <= '0;
         parsed_ff     <= '0;
         first_ff      <= '0;
         err_ff        <= ST_OK;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         sig_ff        <= sig_in;
         ver_ff        <= ver_in;
         name_count_ff <= name_count_in;
         name_off_ff   <= name_off_in;
         exp_count_ff  <= exp_count_in;
         exp_off_ff    <= exp_off_in;
         imp_count_ff  <= imp_count_in;
         imp_off_ff    <= imp_off_in;
         step_ff       <= step_in;
         neg_ff        <= neg_in;
         name_left_ff  <= name_left_in;
         flags_left_ff <= flags_left_in;
         parsed_ff     <= parsed_in;
         first_ff      <= first_in;
         err_ff        <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (in_fire && in_data.last_byte) begin
         snap_valid_ff <= 1'b1;
      end else if (out_free) begin
         snap_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire && in_data.last_byte) begin
         snap_ff <= snap_build;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// ----- rtl/phntc_verdict.sv -----
// Verdict logic: turns a parse snapshot and the expected header values into a result.
// Checks are ranked so that the first one met decides the status.
// Depends on phntc_pkg.
module phntc_verdict (
   input  phntc_pkg::snap_type snap,
   input  logic [31:0]         expected_signature,
   input  logic [15:0]         expected_version,
   output phntc_pkg::rsp_type  result
);
   import phntc_pkg::*;

   status_type status;
   logic       parsed_any;

   assign parsed_any = (snap.names_parsed != 32'd0);

   always_comb begin
      if (snap.byte_count < HEADER_BYTES) begin
         status = ST_SHORT_HEADER;
      end else if (snap.signature != expected_signature) begin
         status = ST_SIGNATURE;
      end else if (snap.version != expected_version) begin
         status = ST_VERSION;
      end else if (snap.name_offset > snap.byte_count || snap.export_offset > snap.byte_count ||
                   snap.import_offset > snap.byte_count) begin
         status = ST_OFFSET_PAST_END;
      end else if (snap.name_offset < HEADER_BYTES) begin
         status = ST_NAME_IN_HEADER;
      end else if (snap.error_code != ST_OK) begin
         status = snap.error_code;
      end else if (!snap.table_done) begin
         status = ST_TRUNCATED;
      end else if (!parsed_any || snap.first_length == 12'd0) begin
         status = ST_EMPTY_FIRST;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      result.ok                = (status == ST_OK);
      result.status            = status;
      result.version           = snap.version;
      result.name_count        = snap.name_count;
      result.names_parsed      = snap.names_parsed;
      result.export_count      = snap.export_count;
      result.import_count      = snap.import_count;
      result.byte_count        = snap.byte_count;
      result.first_name_length = parsed_any ? snap.first_length : 12'd0;
   end

endmodule

// ----- rtl/package_header_name_table_checker_top.sv -----
// After the last byte is accepted, its result passes the input, parse snapshot and
// result registers. Throughput: one byte per cycle, set by the single-byte parse step,
// while no last byte waits for the snapshot slot. Synchronous active-high reset clears
// the parser, the queued result and restores the register defaults; a file's last byte
// also returns the parser to its reset state, so the next byte starts a new file.
module package_header_name_table_checker_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  phntc_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output phntc_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [phntc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [phntc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import phntc_pkg::*;

   logic [31:0] sig_cfg_ff;
   logic [15:0] ver_cfg_ff;
   logic [12:0] max_cfg_ff;

   logic        in_valid_ff;
   req_type     in_data_ff;
   logic        in_fire;

   logic        snap_valid;
   snap_type    snap;
   rsp_type     verdict;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        out_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_cfg_ff <= SIGNATURE_RESET;
         ver_cfg_ff <= VERSION_RESET;
         max_cfg_ff <= NAME_LIMIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIGNATURE: sig_cfg_ff <= csr_data;
            CSR_VERSION:   ver_cfg_ff <= csr_data[15:0];
            CSR_MAX_NAME:  max_cfg_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // hold the input transaction while the parser cannot take it
   assign req_stall = in_valid_ff && !in_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   phntc_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (in_valid_ff),
      .in_data         (in_data_ff),
      .max_name_length (max_cfg_ff),
      .out_free        (out_free),
      .in_fire         (in_fire),
      .snap_valid      (snap_valid),
      .snap            (snap)
   );

   phntc_verdict u_verdict (
      .snap               (snap),
      .expected_signature (sig_cfg_ff),
      .expected_version   (ver_cfg_ff),
      .result             (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && snap_valid) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/phntc_checker.sv -----
// Port-level checks on the result channel of the checker top level.
// Depends on phntc_pkg; bound to package_header_name_table_checker_top.
module phntc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input phntc_pkg::rsp_type rsp_data
);
   import phntc_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result transaction visible after reset");

   a_ok_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.ok == (rsp_data.status == ST_OK)))
      else $error("ok flag disagrees with status");

   a_short_file: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.byte_count < HEADER_BYTES) |-> rsp_data.status == ST_SHORT_HEADER)
      else $error("short file not reported as short header");

   a_pass_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ok) |->
         (rsp_data.names_parsed == rsp_data.name_count && rsp_data.first_name_length != 12'd0))
      else $error("pass reported with an incomplete name table");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result transaction changed");

endmodule

bind package_header_name_table_checker_top phntc_checker u_phntc_checker (.*);

// ----- test/tb_top.sv -----
// Self-checking bench for package_header_name_table_checker_top: streams package files
// byte by byte and checks every verdict against a scoreboard that parses the same bytes.
// Depends on phntc_pkg and the top-level RTL only.
module tb_top;
   import phntc_pkg::*;

   typedef enum logic [2:0] {
      SCAN_HEADER,
      SCAN_SKIP,
      SCAN_INDEX,
      SCAN_NAME,
      SCAN_FLAGS,
      SCAN_DONE
   } scan_phase_t;

   // Byte offsets of the header fields
   localparam int OFF_VERSION       = 4;
   localparam int OFF_NAME_COUNT    = 12;
   localparam int OFF_NAME_OFFSET   = 16;
   localparam int OFF_EXPORT_COUNT  = 20;
   localparam int OFF_EXPORT_OFFSET = 24;
   localparam int OFF_IMPORT_COUNT  = 28;
   localparam int OFF_IMPORT_OFFSET = 32;

   localparam int CYCLE_LIMIT = 400000;

   class verdict_board;
      logic [31:0]  want_signature;
      logic [15:0]  want_version;
      logic [12:0]  name_limit;
      logic [31:0]  pos;
      scan_phase_t  phase;
      logic [31:0]  hdr [8];
      logic [31:0]  acc;
      logic [2:0]   idx_step;
      logic         idx_neg;
      logic [12:0]  name_left;
      logic [2:0]   flags_left;
      logic [31:0]  names_done;
      logic [11:0]  first_len;
      status_type   fault;
      rsp_type      expected_verdicts [$];
      int           errors;
      int           checked;

      function new();
         want_signature = SIGNATURE_RESET;
         want_version   = VERSION_RESET;
         name_limit     = NAME_LIMIT;
         errors         = 0;
         checked        = 0;
         restart();
      endfunction

      function void restart();
         pos = '0;
         phase = SCAN_HEADER;
         foreach (hdr[i]) hdr[i] = '0;
         acc = '0;
         idx_step = '0;
         idx_neg = 1'b0;
         name_left = '0;
         flags_left = '0;
         names_done = '0;
         first_len = '0;
         fault = ST_OK;
      endfunction

      function void apply_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] value);
         case (idx)
            CSR_SIGNATURE: want_signature = value;
            CSR_VERSION:   want_version = value[15:0];
            CSR_MAX_NAME:  name_limit = value[12:0];
            default: ;
         endcase
      endfunction

      function void table_fault(status_type code);
         fault = code;
         phase = SCAN_DONE;
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction

      // Advance the parse by one accepted byte; queue a verdict on the last byte
      function void note_byte(req_type item);
         logic [7:0]  b;
         logic [63:0] wide;
         logic [31:0] lim;
         logic        more;
         int          w;
         rsp_type     v;
         status_type  st;
         b = item.data_byte;
         if (phase == SCAN_HEADER) begin
            w = int'(pos >> 2);
            if (pos[1:0] == 2'd0)
               acc = {24'd0, b};
            else
               acc = acc | ({24'd0, b} << (8 * pos[1:0]));
            if (pos[1:0] == 2'd3) begin
               if (w < 2)
                  hdr[w] = acc;
               else if (w > 2 && w <= 8)
                  hdr[w - 1] = acc;
            end
            if (pos == HEADER_BYTES - 1) begin
               acc = '0;
               phase = (hdr[3] < HEADER_BYTES || hdr[2] == 0) ? SCAN_DONE : SCAN_SKIP;
            end
         end else if (phase != SCAN_DONE) begin
            if (phase == SCAN_SKIP && pos == hdr[3]) begin
               phase = SCAN_INDEX;
               idx_step = '0;
            end
            case (phase)
               SCAN_INDEX: begin
                  if (idx_step == 0) begin
                     idx_neg = b[7];
                     acc = {26'd0, b[5:0]};
                     more = b[6];
                  end else begin
                     wide = {57'd0, b[6:0]} << (6 + 7 * (int'(idx_step) - 1));
                     acc = acc | wide[31:0];
                     more = b[7];
                  end
                  idx_step = idx_step + 3'd1;
                  if (!more) begin
                     idx_step = '0;
                     lim = (name_limit > NAME_LIMIT) ? 32'(NAME_LIMIT) : 32'(name_limit);
                     if (idx_neg || acc == 0 || acc > 32'h7FFF_FFFF || acc > lim) begin
                        table_fault(ST_BAD_LENGTH);
                     end else begin
                        name_left = acc[12:0];
                        if (names_done == 0)
                           first_len = acc[11:0] - 12'd1;
                        phase = SCAN_NAME;
                     end
                  end else if (idx_step >= 5) begin
                     idx_step = '0;
                     table_fault(ST_BAD_LENGTH);
                  end
               end
               SCAN_NAME: begin
                  name_left = name_left - 13'd1;
                  if (name_left == 0) begin
                     if (b != 0) begin
                        table_fault(ST_NO_TERMINATOR);
                     end else begin
                        phase = SCAN_FLAGS;
                        flags_left = 3'd4;
                     end
                  end
               end
               SCAN_FLAGS: begin
                  flags_left = flags_left - 3'd1;
                  if (flags_left == 0) begin
                     names_done = names_done + 1;
                     if (names_done == hdr[2]) begin
                        phase = SCAN_DONE;
                     end else begin
                        phase = SCAN_INDEX;
                        idx_step = '0;
                     end
                  end
               end
               default: ;
            endcase
         end
         if (pos != POSITION_MAX)
            pos = pos + 1;

         if (item.last_byte) begin
            if (pos < HEADER_BYTES)
               st = ST_SHORT_HEADER;
            else if (hdr[0] != want_signature)
               st = ST_SIGNATURE;
            else if (hdr[1][15:0] != want_version)
               st = ST_VERSION;
            else if (hdr[3] > pos || hdr[5] > pos || hdr[7] > pos)
               st = ST_OFFSET_PAST_END;
            else if (hdr[3] < HEADER_BYTES)
               st = ST_NAME_IN_HEADER;
            else if (fault != ST_OK)
               st = fault;
            else if (phase != SCAN_DONE)
               st = ST_TRUNCATED;
            else if (names_done == 0 || first_len == 0)
               st = ST_EMPTY_FIRST;
            else
               st = ST_OK;
            v.ok                = (st == ST_OK);
            v.status            = st;
            v.version           = hdr[1][15:0];
            v.name_count        = hdr[2];
            v.names_parsed      = names_done;
            v.export_count      = hdr[4];
            v.import_count      = hdr[6];
            v.byte_count        = pos;
            v.first_name_length = (names_done != 0) ? first_len : 12'd0;
            expected_verdicts.push_back(v);
            restart();
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_verdict(rsp_type got);
         rsp_type want;
         if (expected_verdicts.size() == 0) begin
            $error("verdict arrived with nothing expected: %p", got);
            errors++;
            return;
         end
         want = expected_verdicts.pop_front();
         checked++;
         compare_field("ok", 32'(want.ok), 32'(got.ok));
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("version", 32'(want.version), 32'(got.version));
         compare_field("name_count", want.name_count, got.name_count);
         compare_field("names_parsed", want.names_parsed, got.names_parsed);
         compare_field("export_count", want.export_count, got.export_count);
         compare_field("import_count", want.import_count, got.import_count);
         compare_field("byte_count", want.byte_count, got.byte_count);
         compare_field("first_name_length", 32'(want.first_name_length),
                       32'(got.first_name_length));
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   verdict_board board;
   logic [7:0]   file_bytes [$];
   bit           calm = 1'b0;
   int           cycles = 0;
   int           files_sent = 0;
   int           bytes_sent = 0;

   package_header_name_table_checker_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, board.pending());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 22);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_byte(req_data);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_verdict(rsp_data);
   end

   function automatic void put_le(logic [31:0] value, int nbytes);
      int i;
      for (i = 0; i < nbytes; i++)
         file_bytes.push_back(value[8*i +: 8]);
   endfunction

   function automatic void set_le(int at, logic [31:0] value);
      int i;
      for (i = 0; i < 4; i++)
         file_bytes[at + i] = value[8*i +: 8];
   endfunction

   // Export and import counts are random; export and import offsets start at zero
   function automatic void put_header(logic [31:0] sig, logic [15:0] ver,
                                      logic [31:0] ncount, logic [31:0] noff);
      file_bytes.delete();
      put_le(sig, 4);
      put_le(32'(ver), 2);
      put_le($urandom, 2);
      put_le($urandom, 4);
      put_le(ncount, 4);
      put_le(noff, 4);
      put_le($urandom, 4);
      put_le('0, 4);
      put_le($urandom, 4);
      put_le('0, 4);
   endfunction

   // Signed variable-length index; pad adds continuation bytes with no payload
   function automatic void put_length(logic [31:0] mag, bit neg, int pad);
      logic [31:0] rest;
      logic [6:0]  chunk;
      int          extra;
      rest = mag >> 6;
      extra = pad;
      file_bytes.push_back({neg, (rest != 0 || extra > 0), mag[5:0]});
      while (rest != 0 || extra > 0) begin
         if (rest == 0)
            extra--;
         chunk = rest[6:0];
         rest = rest >> 7;
         file_bytes.push_back({(rest != 0 || extra > 0), chunk});
      end
   endfunction

   function automatic void put_entry(int len, int pad);
      put_length(32'(len), 1'b0, pad);
      repeat (len - 1) file_bytes.push_back(8'($urandom));
      file_bytes.push_back(8'h00);
      repeat (4) file_bytes.push_back(8'($urandom));
   endfunction

   function automatic void build_plain(int len, int names);
      put_header(board.want_signature, board.want_version, 32'(names), HEADER_BYTES);
      repeat (names) put_entry(len, 0);
   endfunction

   function automatic void build_random_file();
      logic [31:0] lim;
      int          kind, names, gap, cap, len, roll, i, keep;
      kind = $urandom_range(0, 99);
      file_bytes.delete();
      if (kind < 8) begin
         repeat ($urandom_range(1, 60)) file_bytes.push_back(8'($urandom));
         return;
      end
      names = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
      put_header(board.want_signature, board.want_version, 32'(names),
                 HEADER_BYTES + 32'(gap));
      repeat (gap) file_bytes.push_back(8'($urandom));
      lim = (board.name_limit > NAME_LIMIT) ? 32'(NAME_LIMIT) : 32'(board.name_limit);
      cap = (lim == 0) ? 24 : int'(lim);
      for (i = 0; i < names; i++) begin
         roll = $urandom_range(0, 79);
         if (roll == 0) begin
            // over the limit: everything after it is only counted
            put_length(32'(cap + 1), 1'b0, 0);
            break;
         end
         if (roll == 1)
            len = cap;
         else if (roll < 6)
            len = $urandom_range(1, (cap < 300) ? cap : 300);
         else
            len = $urandom_range(1, (cap < 24) ? cap : 24);
         put_entry(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
      end
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
      set_le(OFF_EXPORT_OFFSET, $urandom_range(0, file_bytes.size()));
      set_le(OFF_IMPORT_OFFSET, $urandom_range(0, file_bytes.size()));
      if (kind < 33) begin
         case ($urandom_range(0, 5))
            0: begin
               keep = $urandom_range(1, file_bytes.size() - 1);
               file_bytes = file_bytes[0:keep-1];
            end
            1: file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
            2: begin
               if (file_bytes.size() > 36)
                  file_bytes[$urandom_range(36, file_bytes.size() - 1)] = 8'($urandom);
            end
            3: set_le(OFF_NAME_COUNT, 32'(names + $urandom_range(1, 3)));
            4: set_le(OFF_NAME_OFFSET + 8 * $urandom_range(0, 2),
                      32'(file_bytes.size() + $urandom_range(1, 1000)));
            default: set_le(OFF_NAME_OFFSET, $urandom_range(0, 35));
         endcase
      end
   endfunction

   task automatic send_file();
      int i;
      for (i = 0; i < file_bytes.size(); i++) begin
         while (!calm && $urandom_range(0, 99) < 22) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data <= '{data_byte: file_bytes[i], last_byte: (i == file_bytes.size() - 1)};
         @(posedge clock);
         while (req_stall) @(posedge clock);
         bytes_sent++;
      end
      files_sent++;
   endtask

   // Drain every outstanding verdict, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.apply_csr(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_batch();
      int start_bytes, start_files;
      start_bytes = bytes_sent;
      start_files = files_sent;
      while (bytes_sent - start_bytes < 240 || files_sent - start_files < 12) begin
         build_random_file();
         send_file();
      end
   endtask

   task automatic run_directed();
      // short header: a lone byte, then one byte short of a header
      file_bytes = {8'hFF};
      send_file();
      build_plain(2, 1);
      file_bytes = file_bytes[0:34];
      send_file();
      build_plain(2, 1);
      send_file();
      build_plain(5, 3);
      send_file();
      build_plain(2, 1);
      set_le(0, ~board.want_signature);
      send_file();
      build_plain(2, 1);
      file_bytes[OFF_VERSION] = ~file_bytes[OFF_VERSION];
      send_file();
      // offsets past the end of the file, then a name offset inside the header
      build_plain(2, 1);
      set_le(OFF_NAME_OFFSET, 32'hFFFF_FFFF);
      send_file();
      build_plain(2, 1);
      set_le(OFF_EXPORT_OFFSET, 32'(file_bytes.size() + 1));
      send_file();
      build_plain(2, 1);
      set_le(OFF_IMPORT_OFFSET, 32'(file_bytes.size() + 1));
      send_file();
      build_plain(2, 1);
      set_le(OFF_NAME_OFFSET, 32'd0);
      send_file();
      // no names at all, then a first name holding only its terminator
      build_plain(2, 0);
      send_file();
      build_plain(1, 1);
      send_file();
      // negative and zero lengths, then a length one over the name limit
      build_plain(2, 2);
      file_bytes[36] = 8'h82;
      send_file();
      build_plain(2, 1);
      file_bytes[36] = 8'h00;
      send_file();
      put_header(board.want_signature, board.want_version, 32'd1, HEADER_BYTES);
      put_length(32'(NAME_LIMIT) + 32'd1, 1'b0, 0);
      file_bytes = {file_bytes, 8'h61, 8'h00};
      send_file();
      // index running past five bytes, and one above the largest magnitude
      put_header(board.want_signature, board.want_version, 32'd1, HEADER_BYTES);
      file_bytes = {file_bytes, 8'h41, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00};
      send_file();
      put_header(board.want_signature, board.want_version, 32'd1, HEADER_BYTES);
      file_bytes = {file_bytes, 8'h40, 8'h80, 8'h80, 8'h80, 8'h10, 8'h00};
      send_file();
      // bits beyond bit 31 drop out, leaving a length of two
      put_header(board.want_signature, board.want_version, 32'd1, HEADER_BYTES);
      file_bytes = {file_bytes, 8'h42, 8'h80, 8'h80, 8'h80, 8'h20, 8'h7A, 8'h00};
      file_bytes = {file_bytes, 8'hFF, 8'h00, 8'hFF, 8'h00};
      send_file();
      build_plain(3, 1);
      file_bytes[39] = 8'h5A;
      send_file();
      // end of file inside an index, a name, the flags and before the table
      build_plain(100, 1);
      file_bytes = file_bytes[0:36];
      send_file();
      build_plain(10, 1);
      file_bytes = file_bytes[0:39];
      send_file();
      build_plain(2, 1);
      file_bytes = file_bytes[0:file_bytes.size()-3];
      send_file();
      build_plain(2, 1);
      set_le(OFF_NAME_OFFSET, 32'd40);
      file_bytes = file_bytes[0:39];
      send_file();
      // longest allowed name with trailing bytes
      build_plain(int'(NAME_LIMIT), 1);
      file_bytes = {file_bytes, 8'h00, 8'hFF, 8'h55};
      send_file();
      build_plain(2, 1);
      set_le(OFF_NAME_COUNT, 32'hFFFF_FFFF);
      set_le(OFF_EXPORT_COUNT, 32'hFFFF_FFFF);
      set_le(OFF_IMPORT_COUNT, 32'h0000_0000);
      send_file();
   endtask

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      random_batch();
      settle();

      csr_write(CSR_SIGNATURE, 32'h0000_0000);
      csr_write(CSR_VERSION, 32'h0000_0000);
      csr_write(CSR_MAX_NAME, 32'd1);
      random_batch();
      settle();

      // keep both sides free of random gaps and stalls for the whole batch
      calm = 1'b1;
      csr_write(CSR_SIGNATURE, 32'hFFFF_FFFF);
      csr_write(CSR_VERSION, 32'h0000_FFFF);
      csr_write(CSR_MAX_NAME, 32'(NAME_LIMIT));
      random_batch();
      settle();
      calm = 1'b0;

      csr_write(CSR_MAX_NAME, 32'd0);
      random_batch();
      settle();

      csr_write(CSR_SIGNATURE, $urandom);
      csr_write(CSR_VERSION, 32'hFFFF_FFFF);
      csr_write(CSR_MAX_NAME, 32'hFFFF_FFFF);
      random_batch();
      settle();

      csr_write(CSR_SIGNATURE, $urandom);
      csr_write(CSR_VERSION, $urandom);
      csr_write(CSR_MAX_NAME, $urandom_range(2, 64));
      random_batch();
      settle();

      $display("Streamed %0d files (%0d bytes) under six register settings.",
               files_sent, bytes_sent);
      $display("Verdicts checked: %0d, mismatches: %0d.", board.checked, board.errors);
      if (board.errors == 0 && board.pending() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
